// ===== src/sensor_frame_receiver_core_assert.svh =====
// assertion macros used by the checker file
`ifndef SENSOR_FRAME_RECEIVER_CORE_ASSERT_SVH
`define SENSOR_FRAME_RECEIVER_CORE_ASSERT_SVH

// property checked only while out of reset
`define SFR_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// property checked at every edge, reset included
`define SFR_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== src/sfr_pkg.sv =====
// shared types, constants and crc function of the sensor frame receiver
package sfr_pkg;

    localparam int FRAME_BYTES = 17;
    localparam int BYTE_W      = 8;
    localparam int CRC_W       = 16;
    localparam int COUNT_W     = 5;
    localparam int CFG_INDEX_W = 8;
    localparam int TDATA_W     = 112;
    localparam int TUSER_W     = 2;
    localparam int WORD_W      = 16;
    localparam int CENTI_W     = 15;

    localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
    localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;

    localparam logic [CFG_INDEX_W-1:0] REG_DEVICE_ADDRESS = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FUNCTION_CODE  = 8'd1;
    localparam logic [BYTE_W-1:0]      DEVICE_ADDRESS_RST = 8'h01;
    localparam logic [BYTE_W-1:0]      FUNCTION_CODE_RST  = 8'h03;

    localparam logic [COUNT_W-1:0] GOOD_LENGTH  = 5'd14;
    localparam logic [COUNT_W-1:0] HEADER_BYTES = 5'd3;
    localparam logic [COUNT_W-1:0] COUNT_MAX    = 5'd31;
    localparam logic [BYTE_W-1:0]  MIN_LENGTH   = 8'd2;
    localparam logic [BYTE_W-1:0]  MAX_LENGTH   = 8'd18;

    localparam logic [13:0]        HUM_SCALE   = 14'd12500;
    localparam logic [CENTI_W-1:0] HUM_OFFSET  = 15'h7DA8;  // -600
    localparam logic [14:0]        TEMP_SCALE  = 15'd17572;
    localparam logic [CENTI_W-1:0] TEMP_OFFSET = 15'h6DB3;  // -4685

    typedef enum logic [2:0] {
        PH_ADDR    = 3'd0,
        PH_FUNC    = 3'd1,
        PH_LEN     = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_CRC_LO  = 3'd4,
        PH_CRC_HI  = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK  = 2'd0,
        ST_CRC = 2'd1,
        ST_LEN = 2'd2
    } status_t;

    // control from the frame sequencer to the byte chain and result stage
    typedef struct packed {
        logic    store;      // shift the accepted word into the byte chain
        logic    done;       // frame ends with this word
        status_t status;     // frame status, valid with done
        logic    at_crc_hi;  // next word closes a frame
    } ctrl_t;

    function automatic logic [CRC_W-1:0] crc_step(input logic [CRC_W-1:0] crc_in,
                                                  input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc_in ^ {8'h00, b};
        for (int i = 0; i < BYTE_W; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ===== src/sensor_frame_receiver_core.sv =====
// top level of the sensor frame receiver: sequencer, byte chain and result register
// a result word is registered and shown in the cycle after the crc high byte is accepted
// throughput: one input word per cycle unless stalled; the byte chain and crc step take a word every cycle
// input stalls only while a result is still unread and the next word would close a frame
// reset: synchronous, active low; hunts for an address, registers return to 0x01 and 0x03
module sensor_frame_receiver_core (
    input  logic                             aclk,
    input  logic                             aresetn,
    // input stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,   // [7:0] rx_byte
    // result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [15:0] co2_ppm, [31:16] tvoc_level, [47:32] formaldehyde_level,
    // [63:48] fine_dust_level, [78:64] humidity_centi, [93:79] temperature_centi,
    // [109:94] coarse_dust_level, [111:110] zero
    output logic [sfr_pkg::TDATA_W-1:0]      m_tdata,
    output logic [sfr_pkg::TUSER_W-1:0]      m_tuser,   // [1:0] frame_status
    // configuration write channel
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [sfr_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [7:0]                       cfg_data
);
    import sfr_pkg::*;

    // configuration registers
    logic [BYTE_W-1:0] dev_addr_reg, dev_addr_next;
    logic [BYTE_W-1:0] func_code_reg, func_code_next;

    // result register
    logic               m_tvalid_reg, m_tvalid_next;
    logic [TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [TUSER_W-1:0] m_tuser_reg, m_tuser_next;

    ctrl_t              ctl;
    logic               s_accept;
    logic [BYTE_W-1:0]  cell_q [FRAME_BYTES];

    logic [WORD_W-1:0]  co2_w, tvoc_w, form_w, fine_w, hum_w, temp_w, coarse_w;
    logic [29:0]        hum_prod;
    logic [30:0]        temp_prod;
    logic [CENTI_W-1:0] hum_centi, temp_centi;

    assign cfg_ready = 1'b1;

    always_comb begin
        dev_addr_next  = dev_addr_reg;
        func_code_next = func_code_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_DEVICE_ADDRESS: dev_addr_next  = cfg_data;
                REG_FUNCTION_CODE:  func_code_next = cfg_data;
                default: begin
                    // no register at this index
                end
            endcase
        end
    end

    // a closing word waits while the previous result is still unread
    assign s_tready = !(m_tvalid_reg && ctl.at_crc_hi);
    assign s_accept = s_tvalid && s_tready;

    sfr_ctrl u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .accept         (s_accept),
        .rx_byte        (s_tdata),
        .device_address (dev_addr_reg),
        .function_code  (func_code_reg),
        .ctl            (ctl)
    );

    // byte chain: frame byte i sits in cell FRAME_BYTES-1-i once a full frame is in
    generate
        for (genvar k = 0; k < FRAME_BYTES; k++) begin : g_cell
            if (k == 0) begin : g_head
                sfr_cell u_cell (
                    .aclk     (aclk),
                    .shift_en (ctl.store),
                    .d_in     (s_tdata),
                    .q_out    (cell_q[k])
                );
            end else begin : g_body
                sfr_cell u_cell (
                    .aclk     (aclk),
                    .shift_en (ctl.store),
                    .d_in     (cell_q[k-1]),
                    .q_out    (cell_q[k])
                );
            end
        end
    endgenerate

    // big-endian sensor words from frame bytes 3..16
    assign co2_w    = {cell_q[FRAME_BYTES-1-3],  cell_q[FRAME_BYTES-1-4]};
    assign tvoc_w   = {cell_q[FRAME_BYTES-1-5],  cell_q[FRAME_BYTES-1-6]};
    assign form_w   = {cell_q[FRAME_BYTES-1-7],  cell_q[FRAME_BYTES-1-8]};
    assign fine_w   = {cell_q[FRAME_BYTES-1-9],  cell_q[FRAME_BYTES-1-10]};
    assign hum_w    = {cell_q[FRAME_BYTES-1-11], cell_q[FRAME_BYTES-1-12]};
    assign temp_w   = {cell_q[FRAME_BYTES-1-13], cell_q[FRAME_BYTES-1-14]};
    assign coarse_w = {cell_q[FRAME_BYTES-1-15], cell_q[FRAME_BYTES-1-16]};

    // scale to hundredths, wrap to 15 bits two's complement
    assign hum_prod   = 30'(hum_w) * 30'(HUM_SCALE);
    assign temp_prod  = 31'(temp_w) * 31'(TEMP_SCALE);
    assign hum_centi  = {1'b0, hum_prod[29:16]} + HUM_OFFSET;
    assign temp_centi = temp_prod[30:16] + TEMP_OFFSET;

    always_comb begin
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        if (ctl.done) begin
            m_tvalid_next = 1'b1;
            m_tuser_next  = ctl.status;
            m_tdata_next  = '0;
            // a bad frame carries all-zero sensor fields
            if (ctl.status == ST_OK) begin
                m_tdata_next = {2'b00, coarse_w, temp_centi, hum_centi,
                                fine_w, form_w, tvoc_w, co2_w};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dev_addr_reg  <= DEVICE_ADDRESS_RST;
            func_code_reg <= FUNCTION_CODE_RST;
            m_tvalid_reg  <= 1'b0;
        end else begin
            dev_addr_reg  <= dev_addr_next;
            func_code_reg <= func_code_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ===== src/sfr_cell.sv =====
// one byte cell of the frame byte chain
module sfr_cell (
    input  logic                      aclk,
    input  logic                      shift_en,
    input  logic [sfr_pkg::BYTE_W-1:0] d_in,
    output logic [sfr_pkg::BYTE_W-1:0] q_out
);
    import sfr_pkg::*;

    logic [BYTE_W-1:0] data_reg;
    logic [BYTE_W-1:0] data_next;

    always_comb begin
        data_next = shift_en ? d_in : data_reg;
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign q_out = data_reg;

endmodule

// ===== src/sfr_ctrl.sv =====
// frame sequencer: address and function match, length check, crc
module sfr_ctrl (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       accept,
    input  logic [sfr_pkg::BYTE_W-1:0] rx_byte,
    input  logic [sfr_pkg::BYTE_W-1:0] device_address,
    input  logic [sfr_pkg::BYTE_W-1:0] function_code,
    output sfr_pkg::ctrl_t             ctl
);
    import sfr_pkg::*;

    phase_t             phase_reg, phase_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [COUNT_W-1:0] length_reg, length_next;
    logic [CRC_W-1:0]   crc_reg, crc_next;
    logic [BYTE_W-1:0]  crc_lo_reg, crc_lo_next;

    logic               store;
    logic               fresh;   // frame restarts with this word
    logic               clear;   // back to hunting, word dropped
    logic               load_len;
    logic               take_lo;
    logic               done;
    status_t            status;
    logic [COUNT_W-1:0] count_inc;
    logic               len_ok;

    assign len_ok    = (rx_byte >= MIN_LENGTH) && (rx_byte <= MAX_LENGTH);
    assign count_inc = (count_reg == COUNT_MAX) ? count_reg : count_reg + 5'd1;

    // next state
    always_comb begin
        phase_next = phase_reg;
        if (accept) begin
            case (phase_reg)
                PH_ADDR: begin
                    if (rx_byte == device_address) phase_next = PH_FUNC;
                end
                PH_FUNC: begin
                    phase_next = (rx_byte == function_code) ? PH_LEN : PH_ADDR;
                end
                PH_LEN: begin
                    phase_next = len_ok ? PH_PAYLOAD : PH_ADDR;
                end
                PH_PAYLOAD: begin
                    if (count_inc == length_reg + HEADER_BYTES) phase_next = PH_CRC_LO;
                end
                PH_CRC_LO: begin
                    phase_next = PH_CRC_HI;
                end
                PH_CRC_HI: begin
                    phase_next = PH_ADDR;
                end
                default: begin
                    phase_next = PH_ADDR;
                end
            endcase
        end
    end

    // outputs
    always_comb begin
        store    = 1'b0;
        fresh    = 1'b0;
        clear    = 1'b0;
        load_len = 1'b0;
        take_lo  = 1'b0;
        done     = 1'b0;
        status   = ST_OK;
        if (length_reg != GOOD_LENGTH) begin
            status = ST_LEN;
        end else if (crc_reg != {rx_byte, crc_lo_reg}) begin
            status = ST_CRC;
        end
        if (accept) begin
            case (phase_reg)
                PH_ADDR: begin
                    if (rx_byte == device_address) begin
                        store = 1'b1;
                        fresh = 1'b1;
                    end
                end
                PH_FUNC: begin
                    store = (rx_byte == function_code);
                    clear = (rx_byte != function_code);
                end
                PH_LEN: begin
                    store    = len_ok;
                    load_len = len_ok;
                    clear    = !len_ok;
                end
                PH_PAYLOAD: begin
                    store = 1'b1;
                end
                PH_CRC_LO: begin
                    take_lo = 1'b1;
                end
                PH_CRC_HI: begin
                    done  = 1'b1;
                    clear = 1'b1;
                end
                default: begin
                    clear = 1'b1;
                end
            endcase
        end
    end

    // counters, length and crc
    always_comb begin
        count_next  = count_reg;
        crc_next    = crc_reg;
        length_next = load_len ? rx_byte[COUNT_W-1:0] : length_reg;
        crc_lo_next = take_lo ? rx_byte : crc_lo_reg;
        if (clear) begin
            count_next = '0;
            crc_next   = CRC_INIT;
        end else if (store) begin
            count_next = fresh ? 5'd1 : count_inc;
            crc_next   = crc_step(fresh ? CRC_INIT : crc_reg, rx_byte);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_ADDR;
            count_reg  <= '0;
            length_reg <= '0;
            crc_reg    <= CRC_INIT;
            crc_lo_reg <= '0;
        end else begin
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            length_reg <= length_next;
            crc_reg    <= crc_next;
            crc_lo_reg <= crc_lo_next;
        end
    end

    assign ctl.store     = store;
    assign ctl.done      = done;
    assign ctl.status    = status;
    assign ctl.at_crc_hi = (phase_reg == PH_CRC_HI);

endmodule

// ===== src/sfr_checker.sv =====
// port-level checker of the sensor frame receiver and its bind
`include "sensor_frame_receiver_core_assert.svh"

module sfr_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [sfr_pkg::TDATA_W-1:0]     m_tdata,
    input logic [sfr_pkg::TUSER_W-1:0]     m_tuser
);
    import sfr_pkg::*;

    `SFR_ASSERT(a_hold_stalled, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")
    `SFR_ASSERT(a_bad_frame_zero, aclk, aresetn, m_tvalid && (m_tuser != ST_OK) |-> (m_tdata == '0), "bad frame carries sensor data")
    `SFR_ASSERT(a_pad_zero, aclk, aresetn, m_tvalid |-> (m_tdata[TDATA_W-1:110] == '0), "padding bits set")
    `SFR_ASSERT(a_ready_when_empty, aclk, aresetn, !m_tvalid |-> s_tready, "input stalled with empty output")
    `SFR_ASSERT_ALWAYS(a_reset_clears, aclk, !aresetn |=> !m_tvalid, "result valid after reset")

endmodule

bind sensor_frame_receiver_core sfr_checker u_sfr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== sim/sensor_frame_receiver_core_tb.sv =====
// self-checking testbench of the sensor frame receiver core: directed table, then random frames
`timescale 1ns / 1ps

module sensor_frame_receiver_core_tb;
    import sfr_pkg::*;

    localparam int CLK_HALF     = 10;
    localparam int TIMEOUT_NS   = 20_000_000;
    localparam int PHASES       = 8;
    localparam int PHASE_WORDS  = 228;
    localparam int MAX_GAP      = 24;
    localparam int CFG_SLACK    = 4;
    localparam int END_SLACK    = 10;
    localparam int DRAIN_LIMIT  = 5000;
    localparam int PRINT_CAP    = 40;
    localparam int DIR_ROWS     = 24;
    localparam int HUM_MUL      = 12500;
    localparam int HUM_OFS      = -600;
    localparam int TEMP_MUL     = 17572;
    localparam int TEMP_OFS     = -4685;

    // one decoded frame as it leaves the block
    typedef struct packed {
        status_t     status;
        logic [15:0] co2;
        logic [15:0] tvoc;
        logic [15:0] hcho;
        logic [15:0] pm25;
        logic [14:0] humidity;
        logic [14:0] temperature;
        logic [15:0] pm10;
    } sensor_word_t;

    // crc rows take their byte from the running crc of the frame being sent
    typedef enum logic [1:0] {
        ROW_BYTE,
        ROW_CRC_LO,
        ROW_CRC_HI
    } row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic        start;   // first byte of a frame, restarts the running crc
        logic [7:0]  value;
        logic        typed;   // result given here instead of predicted
        status_t     status;
    } row_t;

    row_t dir_rows [DIR_ROWS] = '{
        // noise that is not the address
        '{ROW_BYTE,   1'b0, 8'h00, 1'b0, ST_OK},
        '{ROW_BYTE,   1'b0, 8'hFF, 1'b0, ST_OK},
        // function mismatch on a byte equal to the address, not taken as a new address
        '{ROW_BYTE,   1'b1, 8'h01, 1'b0, ST_OK},
        '{ROW_BYTE,   1'b0, 8'h01, 1'b0, ST_OK},
        // length above range
        '{ROW_BYTE,   1'b1, 8'h01, 1'b0, ST_OK},
        '{ROW_BYTE,   1'b0, 8'h03, 1'b0, ST_OK},
        '{ROW_BYTE,   1'b0, 8'h13, 1'b0, ST_OK},
        // length below range, byte equal to the address and dropped
        '{ROW_BYTE,   1'b1, 8'h01, 1'b0, ST_OK},
        '{ROW_BYTE,   1'b0, 8'h03, 1'b0, ST_OK},
        '{ROW_BYTE,   1'b0, 8'h01, 1'b0, ST_OK},
        // shortest frame with a correct crc: reported as a length error
        '{ROW_BYTE,   1'b1, 8'h01, 1'b0, ST_OK},
        '{ROW_BYTE,   1'b0, 8'h03, 1'b0, ST_OK},
        '{ROW_BYTE,   1'b0, 8'h02, 1'b0, ST_OK},
        '{ROW_BYTE,   1'b0, 8'h00, 1'b0, ST_OK},
        '{ROW_BYTE,   1'b0, 8'hFF, 1'b0, ST_OK},
        '{ROW_CRC_LO, 1'b0, 8'h00, 1'b0, ST_OK},
        '{ROW_CRC_HI, 1'b0, 8'h00, 1'b1, ST_LEN},
        // shortest frame with a broken crc: length wins over crc
        '{ROW_BYTE,   1'b1, 8'h01, 1'b0, ST_OK},
        '{ROW_BYTE,   1'b0, 8'h03, 1'b0, ST_OK},
        '{ROW_BYTE,   1'b0, 8'h02, 1'b0, ST_OK},
        '{ROW_BYTE,   1'b0, 8'h5A, 1'b0, ST_OK},
        '{ROW_BYTE,   1'b0, 8'hA5, 1'b0, ST_OK},
        '{ROW_BYTE,   1'b0, 8'h00, 1'b0, ST_OK},
        '{ROW_BYTE,   1'b0, 8'hFF, 1'b1, ST_LEN}
    };

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [7:0]             s_tdata   = 8'h00;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [TDATA_W-1:0]     m_tdata;
    logic [TUSER_W-1:0]     m_tuser;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [7:0]             cfg_data  = 8'h00;

    // receiver-side copy of the block state
    phase_t       rx_phase   = PH_ADDR;
    logic [4:0]   rx_count   = '0;
    logic [4:0]   rx_len     = '0;
    logic [15:0]  rx_crc     = CRC_INIT;
    logic [7:0]   rx_crc_lo  = 8'h00;
    logic [7:0]   rx_bytes [FRAME_BYTES];
    logic [7:0]   match_addr = DEVICE_ADDRESS_RST;
    logic [7:0]   match_func = FUNCTION_CODE_RST;

    // sender-side copy of the registers, used to build frames
    logic [7:0]   send_addr  = DEVICE_ADDRESS_RST;
    logic [7:0]   send_func  = FUNCTION_CODE_RST;

    sensor_word_t expected_frames [$];
    int           mismatches     = 0;
    int           words_accepted = 0;
    int           words_sent     = 0;
    int           s_idle_pct     = 0;
    int           m_stall_pct    = 0;

    sensor_frame_receiver_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #CLK_HALF aclk = ~aclk;

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= m_stall_pct);
    end

    function automatic logic [15:0] crc_update(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] x;
        x = c ^ {8'h00, b};
        repeat (8) begin
            x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
        end
        return x;
    endfunction

    function automatic logic [14:0] to_centi(input logic [15:0] raw, input int mul,
                                             input int ofs);
        int unsigned prod;
        int          v;
        prod = 32'(mul) * 32'(raw);
        v    = ofs + int'(prod >> 16);
        return v[14:0];
    endfunction

    function automatic logic [15:0] rx_word(input int i);
        return {rx_bytes[i], rx_bytes[i+1]};
    endfunction

    function automatic void rx_restart();
        rx_phase = PH_ADDR;
        rx_count = '0;
        rx_crc   = CRC_INIT;
    endfunction

    function automatic void rx_store(input logic [7:0] b);
        if (rx_count < FRAME_BYTES) rx_bytes[rx_count] = b;
        if (rx_count < COUNT_MAX) rx_count = rx_count + 5'd1;
        rx_crc = crc_update(rx_crc, b);
    endfunction

    // advance the receiver copy by one byte; returns 1 when a frame closes
    function automatic bit decode_rx_byte(input logic [7:0] b, output sensor_word_t r);
        bit closed;
        r      = '0;
        closed = 1'b0;
        case (rx_phase)
            PH_ADDR: begin
                if (b == match_addr) begin
                    rx_restart();
                    rx_store(b);
                    rx_phase = PH_FUNC;
                end
            end
            PH_FUNC: begin
                if (b == match_func) begin
                    rx_store(b);
                    rx_phase = PH_LEN;
                end else begin
                    rx_restart();
                end
            end
            PH_LEN: begin
                if (b >= MIN_LENGTH && b <= MAX_LENGTH) begin
                    rx_len = b[4:0];
                    rx_store(b);
                    rx_phase = PH_PAYLOAD;
                end else begin
                    rx_restart();
                end
            end
            PH_PAYLOAD: begin
                rx_store(b);
                if (rx_count == rx_len + HEADER_BYTES) rx_phase = PH_CRC_LO;
            end
            PH_CRC_LO: begin
                rx_crc_lo = b;
                rx_phase  = PH_CRC_HI;
            end
            PH_CRC_HI: begin
                closed = 1'b1;
                if (rx_len != GOOD_LENGTH) begin
                    r.status = ST_LEN;
                end else if (rx_crc != {b, rx_crc_lo}) begin
                    r.status = ST_CRC;
                end else begin
                    r.status      = ST_OK;
                    r.co2         = rx_word(3);
                    r.tvoc        = rx_word(5);
                    r.hcho        = rx_word(7);
                    r.pm25        = rx_word(9);
                    r.humidity    = to_centi(rx_word(11), HUM_MUL, HUM_OFS);
                    r.temperature = to_centi(rx_word(13), TEMP_MUL, TEMP_OFS);
                    r.pm10        = rx_word(15);
                end
                rx_restart();
            end
            default: begin
                rx_restart();
            end
        endcase
        return closed;
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        mismatches++;
        if (mismatches <= PRINT_CAP) begin
            $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
        end
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) flag_mismatch(what, got, want);
    endtask

    task automatic compare_frame(input sensor_word_t want);
        check_field("frame_status",       32'(m_tuser),           32'(want.status));
        check_field("co2_ppm",            32'(m_tdata[15:0]),     32'(want.co2));
        check_field("tvoc_level",         32'(m_tdata[31:16]),    32'(want.tvoc));
        check_field("formaldehyde_level", 32'(m_tdata[47:32]),    32'(want.hcho));
        check_field("fine_dust_level",    32'(m_tdata[63:48]),    32'(want.pm25));
        check_field("humidity_centi",     32'(m_tdata[78:64]),    32'(want.humidity));
        check_field("temperature_centi",  32'(m_tdata[93:79]),    32'(want.temperature));
        check_field("coarse_dust_level",  32'(m_tdata[109:94]),   32'(want.pm10));
        check_field("tdata padding",      32'(m_tdata[111:110]),  32'd0);
    endtask

    // sample every handshake at the edge, with values from before the edge
    always @(posedge aclk) begin : watch
        sensor_word_t fresh;
        bit           closed;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_frames.size() == 0) begin
                    flag_mismatch("result word with nothing pending", 32'(m_tuser), 32'd0);
                end else begin
                    compare_frame(expected_frames.pop_front());
                end
            end
            if (s_tvalid && s_tready) begin
                closed = decode_rx_byte(s_tdata, fresh);
                if (words_accepted < DIR_ROWS && dir_rows[words_accepted].typed) begin
                    fresh        = '0;
                    fresh.status = dir_rows[words_accepted].status;
                    closed       = 1'b1;
                end
                if (closed) expected_frames.push_back(fresh);
                words_accepted++;
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_DEVICE_ADDRESS: match_addr = cfg_data;
                    REG_FUNCTION_CODE:  match_func = cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // present one input word after a random gap and hold it until taken
    task automatic send_word(input logic [7:0] b);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(0, 99) < s_idle_pct) gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        words_sent++;
    endtask

    task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        // wait with cfg_valid low so a following write starts on a later edge
        @(posedge aclk);
        if (idx == REG_DEVICE_ADDRESS) send_addr = d;
        if (idx == REG_FUNCTION_CODE) send_func = d;
    endtask

    // stop sending until every pending result is back or the wait limit runs out, then let the block settle
    task automatic drain(input int slack);
        int waited;
        waited = 0;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_frames.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (slack) @(posedge aclk);
    endtask

    // frame with random payload; fault 1 or 2 breaks the crc low or high byte,
    // only the first cut words go out
    task automatic send_frame(input int len, input int fault, input int cut);
        logic [7:0]  bytes [$];
        logic [15:0] acc;
        logic [7:0]  flip;
        bytes = {send_addr, send_func, 8'(len)};
        for (int i = 0; i < len; i++) begin
            case ($urandom_range(0, 7))
                0:       bytes.push_back(8'h00);
                1:       bytes.push_back(8'hFF);
                default: bytes.push_back(8'($urandom_range(0, 255)));
            endcase
        end
        acc = CRC_INIT;
        foreach (bytes[i]) acc = crc_update(acc, bytes[i]);
        flip = 8'(1 << $urandom_range(0, 7));
        bytes.push_back(acc[7:0] ^ ((fault == 1) ? flip : 8'h00));
        bytes.push_back(acc[15:8] ^ ((fault == 2) ? flip : 8'h00));
        foreach (bytes[i]) begin
            if (i < cut) send_word(bytes[i]);
        end
    endtask

    // mostly well-formed frames, the rest broken headers, cut frames and noise
    task automatic send_traffic(input int count);
        int         stop_at;
        int         pick;
        int         len;
        logic [7:0] b;
        stop_at = words_sent + count;
        while (words_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                len = ($urandom_range(0, 3) != 0) ? int'(GOOD_LENGTH) : $urandom_range(2, 18);
                send_frame(len, ($urandom_range(0, 99) < 85) ? 0 : $urandom_range(1, 2), 64);
            end else if (pick < 80) begin
                send_word(send_addr);
                do b = 8'($urandom_range(0, 255)); while (b == send_func);
                send_word(b);
            end else if (pick < 88) begin
                send_word(send_addr);
                send_word(send_func);
                b = $urandom_range(0, 1) ? 8'($urandom_range(0, 1)) : 8'($urandom_range(19, 255));
                send_word(b);
            end else if (pick < 94) begin
                send_frame(GOOD_LENGTH, 0, $urandom_range(3, 16));
            end else begin
                repeat ($urandom_range(1, 4)) send_word(8'($urandom_range(0, 255)));
            end
        end
    endtask

    initial begin
        logic [15:0] acc;
        logic [7:0]  b;
        logic [7:0]  a;
        logic [7:0]  f;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed table under the reset register values
        acc = CRC_INIT;
        foreach (dir_rows[i]) begin
            if (dir_rows[i].start) acc = CRC_INIT;
            case (dir_rows[i].kind)
                ROW_CRC_LO: b = acc[7:0];
                ROW_CRC_HI: b = acc[15:8];
                default:    b = dir_rows[i].value;
            endcase
            if (dir_rows[i].kind == ROW_BYTE) acc = crc_update(acc, b);
            send_word(b);
        end

        for (int p = 0; p < PHASES; p++) begin
            case (p % 4)
                0: begin s_idle_pct = 0;  m_stall_pct = 0;  end
                1: begin s_idle_pct = 49; m_stall_pct = 0;  end
                2: begin s_idle_pct = 0;  m_stall_pct = 49; end
                default: begin s_idle_pct = 23; m_stall_pct = 23; end
            endcase
            if (p > 0) begin
                drain(CFG_SLACK);
                a = 8'($urandom_range(0, 255));
                f = 8'($urandom_range(0, 255));
                case (p)
                    1: begin a = 8'h00; f = 8'hFF; end
                    2: begin a = 8'hFF; f = 8'h00; end
                    4: f = a;
                    5: begin a = DEVICE_ADDRESS_RST; f = FUNCTION_CODE_RST; end
                    default: ;
                endcase
                cfg_write(REG_DEVICE_ADDRESS, a);
                cfg_write(REG_FUNCTION_CODE, f);
            end
            send_traffic(PHASE_WORDS / 2);
            // sender holds off until the block has delivered everything
            drain(0);
            send_traffic(PHASE_WORDS / 2);
        end

        drain(END_SLACK);
        if (expected_frames.size() != 0) begin
            flag_mismatch("results never delivered", 32'(expected_frames.size()), 32'd0);
        end
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("status: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+src
src/sfr_pkg.sv
src/sfr_cell.sv
src/sfr_ctrl.sv
src/sensor_frame_receiver_core.sv
src/sfr_checker.sv
sim/sensor_frame_receiver_core_tb.sv
